FILE: src/integer_to_radix_ascii_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the integer to radix ASCII converter
// Both macros check on the rising edge of clk and are quiet while arst_n is
// low. They expand to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_ASSERT_SVH

`ifndef SYNTHESIS

// Condition that must hold at every edge.
`define I2RA_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in a cycle implies the consequent in the same cycle.
`define I2RA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define I2RA_ASSERT(lbl, cond, msg)
`define I2RA_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

FILE: src/i2ra_pkg.sv
// ---------------------------------------------------------------------------
// i2ra_pkg
// Shared constants, types and helpers of the integer to radix ASCII block.
// ---------------------------------------------------------------------------
`default_nettype none

package i2ra_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	// quotient bits retired per divider cycle
	localparam int BITS_PER_STEP = 8;

	localparam logic [5:0] RADIX_MIN   = 6'd2;
	localparam logic [5:0] RADIX_MAX   = 6'd36;
	localparam logic [5:0] RADIX_RESET = 6'd10;

	localparam logic [5:0] DIGIT_NINE = 6'd9;
	localparam logic [5:0] DIGIT_TEN  = 6'd10;

	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_A     = 7'h41;
	localparam logic [6:0] CH_MINUS = 7'h2D;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FETCH,
		ST_SIGN,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic load;       // take a new value
		logic div_step;   // retire one chunk of quotient bits
		logic digit_end;  // chunk closes a digit: store remainder
		logic rd_first;   // read the most significant stored digit
		logic rd_next;    // read the next lower digit
		logic sel_sign;   // drive the minus sign
	} cmd_t;

	typedef struct packed {
		logic q_zero;     // quotient after this step is zero
		logic neg;        // value being converted is negative
		logic idx_zero;   // read pointer at the least significant digit
	} stat_t;

	function automatic logic [6:0] digit_char(input logic [5:0] d);
		logic [6:0] c;
		if (d <= DIGIT_NINE)
			c = CH_ZERO + {1'b0, d};
		else
			c = CH_A + {1'b0, d - DIGIT_TEN};
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: src/integer_to_radix_ascii.sv
// ---------------------------------------------------------------------------
// integer_to_radix_ascii
// Converts a signed integer into its ASCII text in a programmable base.
// ---------------------------------------------------------------------------
// One value is in flight at a time. After the input transfer the divider
// retires 8 quotient bits per cycle, working through the whole quotient for
// each digit; the characters then follow, one per cycle while the sink is
// ready (sign first if negative). The base register (2..36, reset 10,
// out-of-range writes clamp) must only be written while the block is idle.
// Digits 10 and up are 'A'..'Z'; last marks the final character.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_ascii #(
	parameter int VALUE_WIDTH = i2ra_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic [6:0]                    character,
	output      logic                          last,
	input  wire logic                          cfg_wen,
	input  wire logic [5:0]                    cfg_wdata
);
	import i2ra_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	i2ra_ctrl #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	i2ra_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.value     (value),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.character (character),
		.last      (last)
	);

endmodule

`default_nettype wire

FILE: src/i2ra_datapath.sv
// ---------------------------------------------------------------------------
// i2ra_datapath
// Radix register, chunked restoring divider, digit store and output select.
// ---------------------------------------------------------------------------
`default_nettype none

`include "integer_to_radix_ascii_assert.svh"

module i2ra_datapath #(
	parameter int VALUE_WIDTH = i2ra_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire i2ra_pkg::cmd_t                cmd,
	output      i2ra_pkg::stat_t               stat,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	input  wire logic                          cfg_wen,
	input  wire logic [5:0]                    cfg_wdata,
	output      logic [6:0]                    character,
	output      logic                          last
);
	import i2ra_pkg::*;

	localparam int NCHUNK = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int QW     = NCHUNK * BITS_PER_STEP;
	localparam int IW     = $clog2(VALUE_WIDTH);
	localparam int CNTW   = $clog2(VALUE_WIDTH + 1);

	logic [5:0]             rdx_q;
	logic [QW-1:0]          q_q;
	logic [5:0]             rem_q;
	logic [CNTW-1:0]        cnt_q;
	logic                   neg_q;
	logic [IW-1:0]          rd_idx_q;
	logic [5:0]             rd_q;
	logic [5:0]             mem [VALUE_WIDTH];

	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag;
	logic [QW-1:0]          q_t;
	logic [6:0]             rem_t;
	logic [CNTW-1:0]        cnt_m1;
	logic [IW-1:0]          rd_addr;
	logic                   rd_en;

	assign raw = value;
	assign mag = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

	// configuration: clamp into the legal base range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdx_q <= RADIX_RESET;
		end else if (cfg_wen) begin
			if (cfg_wdata < RADIX_MIN)
				rdx_q <= RADIX_MIN;
			else if (cfg_wdata > RADIX_MAX)
				rdx_q <= RADIX_MAX;
			else
				rdx_q <= cfg_wdata;
		end
	end

	// shift dividend bits in MSB first, quotient bits replace them at the bottom
	always_comb begin
		rem_t = {1'b0, rem_q};
		q_t   = q_q;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			rem_t = {rem_t[5:0], q_t[QW-1]};
			q_t   = {q_t[QW-2:0], 1'b0};
			if (rem_t >= {1'b0, rdx_q}) begin
				rem_t  = rem_t - {1'b0, rdx_q};
				q_t[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
		end else if (cmd.load) begin
			rem_q <= '0;
			cnt_q <= '0;
			neg_q <= raw[VALUE_WIDTH-1];
		end else if (cmd.div_step) begin
			rem_q <= cmd.digit_end ? 6'd0 : rem_t[5:0];
			if (cmd.digit_end)
				cnt_q <= cnt_q + CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			q_q <= QW'(mag);
		else if (cmd.div_step)
			q_q <= q_t;
	end

	assign cnt_m1  = cnt_q - CNTW'(1);
	assign rd_en   = cmd.rd_first | cmd.rd_next;
	assign rd_addr = cmd.rd_first ? cnt_m1[IW-1:0] : (rd_idx_q - IW'(1));

	always_ff @(posedge clk) begin
		if (cmd.div_step && cmd.digit_end)
			mem[cnt_q[IW-1:0]] <= rem_t[5:0];
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_idx_q <= '0;
		else if (rd_en)
			rd_idx_q <= rd_addr;
	end

	assign stat.q_zero   = (q_t == '0);
	assign stat.neg      = neg_q;
	assign stat.idx_zero = (rd_idx_q == '0);

	assign character = cmd.sel_sign ? CH_MINUS : digit_char(rd_q);
	assign last      = stat.idx_zero & ~cmd.sel_sign;

	`I2RA_ASSERT(a_radix_range, rdx_q >= RADIX_MIN && rdx_q <= RADIX_MAX, "radix out of range")
	`I2RA_ASSERT(a_rem_below_radix, rem_q < rdx_q, "partial remainder not below radix")
	`I2RA_ASSERT(a_count_bound, cnt_q <= CNTW'(VALUE_WIDTH), "digit count past store depth")
	`I2RA_ASSERT_IMPL(a_read_under, cmd.rd_next, !stat.idx_zero, "read below first digit")

endmodule

`default_nettype wire

FILE: src/i2ra_ctrl.sv
// ---------------------------------------------------------------------------
// i2ra_ctrl
// Sequencer: accept, divide digit by digit, then stream the sign if negative and the digits.
// ---------------------------------------------------------------------------
`default_nettype none

module i2ra_ctrl #(
	parameter int VALUE_WIDTH = i2ra_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output      logic            in_ready,
	output      logic            out_valid,
	input  wire logic            out_ready,
	input  wire i2ra_pkg::stat_t stat,
	output      i2ra_pkg::cmd_t  cmd
);
	import i2ra_pkg::*;

	localparam int NCHUNK = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

	state_t        state_q, state_d;
	logic [CW-1:0] chunk_q, chunk_d;
	logic          chunk_last;

	assign chunk_last = (chunk_q == CW'(NCHUNK - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chunk_q <= '0;
		end else begin
			state_q <= state_d;
			chunk_q <= chunk_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		chunk_d   = chunk_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					chunk_d  = '0;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (chunk_last) begin
					cmd.digit_end = 1'b1;
					chunk_d       = '0;
					if (stat.q_zero)
						state_d = ST_FETCH;
				end else begin
					chunk_d = chunk_q + CW'(1);
				end
			end
			ST_FETCH: begin
				cmd.rd_first = 1'b1;
				state_d      = stat.neg ? ST_SIGN : ST_SEND;
			end
			ST_SIGN: begin
				out_valid    = 1'b1;
				cmd.sel_sign = 1'b1;
				if (out_ready)
					state_d = ST_SEND;
			end
			ST_SEND: begin
				out_valid = 1'b1;
				// on each transfer but the last, fetch the next lower digit behind it
				if (out_ready) begin
					if (stat.idx_zero)
						state_d = ST_IDLE;
					else
						cmd.rd_next = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
